[rtl/lfu_pkg.sv]
// Package: shared constants, types and command/status structs for the LFU cache.
package lfu_pkg;
  localparam int Entries = 16;
  localparam int IdxW = $clog2(Entries);
  localparam int CntW = IdxW + 1;
  localparam logic [4:0] CapReset = 5'd16;
  localparam logic [31:0] MissValue = 32'hFFFF_FFFF;
  localparam logic OpGet = 1'b0;
  localparam logic OpPut = 1'b1;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } lfu_cmd_t;

  typedef struct packed {
    logic last;
  } lfu_status_t;
endpackage

[rtl/lfu_ctrl.sv]
// Controller: sequences the slot scan and the result strobe.
module lfu_ctrl import lfu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  lfu_status_t status_i,
  output lfu_cmd_t    cmd_o
);
  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StScan = 3'b010,
    StDone = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d = StScan;
        end
      end
      StScan: begin
        cmd_o.step = 1'b1;
        if (status_i.last) state_d = StDone;
      end
      StDone: begin
        cmd_o.finish = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign busy = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

[rtl/lfu_dp.sv]
// Datapath: slot storage, one-slot-per-cycle scan for match, free slot and victim.
module lfu_dp import lfu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lfu_cmd_t           cmd_i,
  output lfu_status_t        status_o,
  input  logic               cap_we_i,
  input  logic [4:0]         cap_wdata_i,
  input  logic               operation_i,
  input  logic signed [31:0] lookup_key_i,
  input  logic [30:0]        store_value_i,
  output logic               done_o,
  output logic               hit_o,
  output logic signed [31:0] read_value_o,
  output logic               evicted_o,
  output logic signed [31:0] evicted_key_o
);
  logic [Entries-1:0] valid_q;
  logic [31:0] key_q [Entries];
  logic [30:0] val_q [Entries];
  logic [31:0] cnt_q [Entries];
  logic [63:0] lt_q  [Entries];
  logic [63:0] clk_cnt_q;
  logic [4:0]  cap_q;

  logic        op_q;
  logic [31:0] rkey_q;
  logic [30:0] rval_q;
  logic [IdxW-1:0] idx_q;
  logic        found_q, free_q, best_ok_q;
  logic [IdxW-1:0] fidx_q, free_idx_q, best_q;
  logic [31:0] bcnt_q;
  logic [63:0] blt_q;
  logic [CntW-1:0] used_q;

  logic        m, better;
  logic [CntW-1:0] cap_eff;

  assign status_o.last = (idx_q == IdxW'(Entries - 1));
  assign m = valid_q[idx_q] && (key_q[idx_q] == rkey_q);
  assign better = valid_q[idx_q] && (!best_ok_q || cnt_q[idx_q] < bcnt_q ||
                  (cnt_q[idx_q] == bcnt_q && lt_q[idx_q] < blt_q));
  assign cap_eff = (cap_q > 5'(Entries)) ? CntW'(Entries) : CntW'(cap_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      clk_cnt_q <= '0;
      cap_q <= CapReset;
      done_o <= 1'b0;
      idx_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (cap_we_i) cap_q <= cap_wdata_i;
      if (cmd_i.load) begin
        op_q <= operation_i;
        rkey_q <= lookup_key_i;
        rval_q <= store_value_i;
        idx_q <= '0;
        found_q <= 1'b0;
        free_q <= 1'b0;
        best_ok_q <= 1'b0;
        used_q <= '0;
      end
      if (cmd_i.step) begin
        idx_q <= idx_q + 1'b1;
        if (m && !found_q) begin
          found_q <= 1'b1;
          fidx_q <= idx_q;
        end
        if (valid_q[idx_q]) used_q <= used_q + 1'b1;
        else if (!free_q) begin
          free_q <= 1'b1;
          free_idx_q <= idx_q;
        end
        if (better) begin
          best_ok_q <= 1'b1;
          best_q <= idx_q;
          bcnt_q <= cnt_q[idx_q];
          blt_q <= lt_q[idx_q];
        end
      end
      if (cmd_i.finish) begin
        done_o <= 1'b1;
        hit_o <= found_q;
        read_value_o <= MissValue;
        evicted_o <= 1'b0;
        evicted_key_o <= '0;
        if (found_q && (op_q == OpGet || cap_eff != '0)) begin
          if (cnt_q[fidx_q] != 32'hFFFF_FFFF) cnt_q[fidx_q] <= cnt_q[fidx_q] + 1'b1;
          lt_q[fidx_q] <= clk_cnt_q;
          clk_cnt_q <= clk_cnt_q + 1'b1;
          if (op_q == OpGet) read_value_o <= {1'b0, val_q[fidx_q]};
          else val_q[fidx_q] <= rval_q;
        end else if (!found_q && op_q == OpPut && cap_eff != '0) begin
          if (used_q >= cap_eff || !free_q) begin
            evicted_o <= 1'b1;
            evicted_key_o <= key_q[best_q];
            key_q[best_q] <= rkey_q;
            val_q[best_q] <= rval_q;
            cnt_q[best_q] <= 32'd1;
            lt_q[best_q] <= clk_cnt_q;
          end else begin
            valid_q[free_idx_q] <= 1'b1;
            key_q[free_idx_q] <= rkey_q;
            val_q[free_idx_q] <= rval_q;
            cnt_q[free_idx_q] <= 32'd1;
            lt_q[free_idx_q] <= clk_cnt_q;
          end
          clk_cnt_q <= clk_cnt_q + 1'b1;
        end
      end
    end
  end
endmodule

[rtl/lfu_cache_with_lru_tiebreak.sv]
// Top level: LFU cache with LRU tie break, controller plus scan datapath.
//  channel   | signals                                        | handshake
//  request   | operation_i lookup_key_i store_value_i         | start & !busy
//  result    | hit_o read_value_o evicted_o evicted_key_o     | done_o, one cycle
//  config    | cap_we_i cap_wdata_i                           | cap_we_i
// Each request is loaded, then scanned one slot per cycle, then finished in an
// update state that also drives the result. Reset clears all valid bits at once.
// The receiver cannot stall; done_o lasts one cycle.
module lfu_cache_with_lru_tiebreak import lfu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               operation_i,
  input  logic signed [31:0] lookup_key_i,
  input  logic [30:0]        store_value_i,
  input  logic               cap_we_i,
  input  logic [4:0]         cap_wdata_i,
  output logic               done_o,
  output logic               hit_o,
  output logic signed [31:0] read_value_o,
  output logic               evicted_o,
  output logic signed [31:0] evicted_key_o
);
  lfu_cmd_t    cmd;
  lfu_status_t status;

  lfu_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .busy, .status_i(status), .cmd_o(cmd)
  );

  lfu_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status), .cap_we_i, .cap_wdata_i,
    .operation_i, .lookup_key_i, .store_value_i, .done_o, .hit_o,
    .read_value_o, .evicted_o, .evicted_key_o
  );
endmodule

[rtl/lfu_checker.sv]
// Checker: port-level properties of the LFU cache, bound to the top level.
module lfu_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               done_o,
  input logic               hit_o,
  input logic signed [31:0] read_value_o,
  input logic               evicted_o,
  input logic signed [31:0] evicted_key_o
);
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accept did not raise busy");
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");
  a_evk_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !evicted_o |-> evicted_key_o == 32'sd0) else $error("stray evicted key");
  a_evict_nohit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && evicted_o |-> !hit_o && read_value_o == -32'sd1)
    else $error("eviction on a hit");
endmodule

bind lfu_cache_with_lru_tiebreak lfu_checker u_chk (
  .clk_i, .rst_ni, .start, .busy, .done_o, .hit_o, .read_value_o, .evicted_o,
  .evicted_key_o
);

[tb/tb_lfu_cache_with_lru_tiebreak.sv]
// Testbench for the LFU cache with LRU tie break: directed table plus random traffic.
`timescale 1ns / 1ps
module tb_lfu_cache_with_lru_tiebreak;
  import lfu_pkg::*;

  typedef struct packed {
    logic        hit;
    logic [31:0] rd;
    logic        ev;
    logic [31:0] evk;
  } lookup_result_t;

  typedef enum logic {RowReq, RowCfg} row_kind_e;

  typedef struct {
    row_kind_e      kind;
    logic           op;
    logic [31:0]    key;
    logic [30:0]    val;
    bit             typed;
    lookup_result_t want;
  } table_row_t;

  logic clk_i, rst_ni, start, busy;
  logic operation_i, cap_we_i;
  logic signed [31:0] lookup_key_i;
  logic [30:0] store_value_i;
  logic [4:0] cap_wdata_i;
  logic done_o, hit_o, evicted_o;
  logic signed [31:0] read_value_o, evicted_key_o;

  lfu_cache_with_lru_tiebreak dut (
    .clk_i, .rst_ni, .start, .busy, .operation_i, .lookup_key_i, .store_value_i,
    .cap_we_i, .cap_wdata_i, .done_o, .hit_o, .read_value_o, .evicted_o,
    .evicted_key_o
  );

  // cache shadow state
  logic [4:0]  cap_q;
  bit          sh_valid[Entries];
  logic [31:0] sh_key[Entries];
  logic [30:0] sh_val[Entries];
  logic [31:0] sh_cnt[Entries];
  logic [63:0] sh_stamp[Entries];
  logic [63:0] stamp_clk;

  lookup_result_t want_fifo[16];
  int want_wr, want_rd;
  int errors, quiet_cycles;
  logic [31:0] key_pool[24];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void touch_slot(int s);
    if (sh_cnt[s] != 32'hFFFF_FFFF) sh_cnt[s]++;
    sh_stamp[s] = stamp_clk;
    stamp_clk++;
  endfunction

  function automatic lookup_result_t cache_access(logic op, logic [31:0] key,
                                                  logic [30:0] val);
    lookup_result_t r;
    int pos, slot, used, eff;
    pos = -1;
    slot = -1;
    used = 0;
    eff = (cap_q > Entries) ? Entries : cap_q;
    r = '{hit: 1'b0, rd: MissValue, ev: 1'b0, evk: '0};
    for (int s = 0; s < Entries; s++)
      if (pos < 0 && sh_valid[s] && sh_key[s] == key) pos = s;
    r.hit = (pos >= 0);
    if (op == OpGet) begin
      if (pos >= 0) begin
        touch_slot(pos);
        r.rd = {1'b0, sh_val[pos]};
      end
    end else if (eff != 0) begin
      if (pos >= 0) begin
        sh_val[pos] = val;
        touch_slot(pos);
      end else begin
        for (int s = 0; s < Entries; s++)
          if (sh_valid[s]) used++;
          else if (slot < 0) slot = s;
        if (used >= eff || slot < 0) begin
          slot = -1;
          for (int s = 0; s < Entries; s++)
            if (sh_valid[s] && (slot < 0 || sh_cnt[s] < sh_cnt[slot] ||
                (sh_cnt[s] == sh_cnt[slot] && sh_stamp[s] < sh_stamp[slot])))
              slot = s;
          r.ev = 1'b1;
          r.evk = sh_key[slot];
        end
        sh_valid[slot] = 1'b1;
        sh_key[slot] = key;
        sh_val[slot] = val;
        sh_cnt[slot] = 32'd1;
        sh_stamp[slot] = stamp_clk;
        stamp_clk++;
      end
    end
    return r;
  endfunction

  task automatic drain();
    while (want_wr != want_rd) @(posedge clk_i);
  endtask

  task automatic write_cap(logic [4:0] c);
    start <= 1'b0;
    drain();
    repeat (24) @(posedge clk_i);
    cap_we_i <= 1'b1;
    cap_wdata_i <= c;
    @(posedge clk_i);
    cap_we_i <= 1'b0;
    cap_q = c;
  endtask

  task automatic send(logic op, logic [31:0] key, logic [30:0] val, bit typed,
                      lookup_result_t want);
    lookup_result_t r;
    start <= 1'b1;
    operation_i <= op;
    lookup_key_i <= key;
    store_value_i <= val;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    r = cache_access(op, key, val);
    want_fifo[want_wr % 16] = typed ? want : r;
    want_wr++;
  endtask

  task automatic idle_gap(int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    lookup_result_t w;
    if (rst_ni) begin
      if ((start && !busy) || done_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (done_o) begin
        if (want_wr == want_rd) begin
          errors++;
          if (errors <= 10) $display("unexpected result hit=%0b rd=%h", hit_o, read_value_o);
        end else begin
          w = want_fifo[want_rd % 16];
          want_rd++;
          if (hit_o !== w.hit || read_value_o !== w.rd || evicted_o !== w.ev ||
              evicted_key_o !== w.evk) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp hit=%0b rd=%h ev=%0b evk=%h got %0b %h %0b %h",
                       w.hit, w.rd, w.ev, w.evk, hit_o, read_value_o, evicted_o,
                       evicted_key_o);
          end
        end
      end
      if (quiet_cycles >= 3000) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  localparam lookup_result_t MissR = '{hit: 1'b0, rd: MissValue, ev: 1'b0, evk: '0};
  localparam lookup_result_t PutHitR = '{hit: 1'b1, rd: MissValue, ev: 1'b0, evk: '0};

  table_row_t dir_rows[] = '{
    '{RowReq, OpGet, 32'h0000_0005, 31'd0, 1, MissR},
    '{RowReq, OpPut, 32'h8000_0000, 31'h7FFF_FFFF, 1, MissR},
    '{RowReq, OpPut, 32'h7FFF_FFFF, 31'd0, 1, MissR},
    '{RowReq, OpGet, 32'h8000_0000, 31'h5555_5555, 1,
      '{hit: 1'b1, rd: 32'h7FFF_FFFF, ev: 1'b0, evk: '0}},
    '{RowReq, OpPut, 32'h7FFF_FFFF, 31'h2AAA_AAAA, 1, PutHitR},
    '{RowReq, OpGet, 32'h7FFF_FFFF, 31'd0, 0, MissR},
    '{RowReq, OpPut, 32'hFFFF_FFFF, 31'd7, 1, MissR},
    '{RowCfg, OpGet, 32'd2, 31'd0, 0, MissR},
    '{RowReq, OpPut, 32'h0000_0000, 31'd1, 0, MissR},
    '{RowReq, OpPut, 32'h0000_0011, 31'd2, 0, MissR},
    '{RowReq, OpGet, 32'h0000_0011, 31'd0, 0, MissR},
    '{RowReq, OpPut, 32'h0000_0022, 31'd3, 0, MissR},
    '{RowReq, OpPut, 32'h0000_0033, 31'd4, 0, MissR},
    '{RowCfg, OpGet, 32'd0, 31'd0, 0, MissR},
    '{RowReq, OpPut, 32'h0000_0044, 31'd5, 1, MissR},
    '{RowReq, OpPut, 32'h8000_0000, 31'd9, 0, MissR},
    '{RowReq, OpGet, 32'h8000_0000, 31'd0, 0, MissR},
    '{RowCfg, OpGet, 32'd31, 31'd0, 0, MissR},
    '{RowReq, OpPut, 32'hDEAD_BEEF, 31'h1234_5678, 0, MissR},
    '{RowReq, OpGet, 32'hDEAD_BEEF, 31'd0, 0, MissR}
  };

  initial begin
    logic [4:0] caps[7] = '{5'd16, 5'd4, 5'd1, 5'd0, 5'd31, 5'd7, 5'd16};
    int pcts[7] = '{0, 69, 33, 0, 69, 33, 0};
    logic [31:0] k;
    logic op;
    rst_ni = 1'b0;
    start = 1'b0;
    operation_i = 1'b0;
    lookup_key_i = '0;
    store_value_i = '0;
    cap_we_i = 1'b0;
    cap_wdata_i = '0;
    errors = 0;
    quiet_cycles = 0;
    want_wr = 0;
    want_rd = 0;
    cap_q = CapReset;
    stamp_clk = '0;
    for (int s = 0; s < Entries; s++) begin
      sh_valid[s] = 1'b0;
      sh_key[s] = '0;
      sh_val[s] = '0;
      sh_cnt[s] = '0;
      sh_stamp[s] = '0;
    end
    foreach (key_pool[i]) key_pool[i] = (i < 8) ? 32'(i) : 32'($urandom);
    key_pool[8] = 32'h8000_0000;
    key_pool[9] = 32'h7FFF_FFFF;
    key_pool[10] = 32'hFFFF_FFFF;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      if (dir_rows[i].kind == RowCfg) write_cap(dir_rows[i].key[4:0]);
      else send(dir_rows[i].op, dir_rows[i].key, dir_rows[i].val,
                dir_rows[i].typed, dir_rows[i].want);

    foreach (caps[p]) begin
      write_cap(caps[p]);
      for (int n = 0; n < 130; n++) begin
        op = 1'($urandom_range(1));
        k = ($urandom_range(9) == 0) ? 32'($urandom)
            : key_pool[$urandom_range((caps[p] < 4) ? 5 : 23)];
        send(op, k, 31'($urandom), 1'b0, MissR);
        if (n == 65) begin
          start <= 1'b0;
          drain();
        end else if (n % 40 < 30) idle_gap(pcts[p]);
      end
    end

    start <= 1'b0;
    drain();
    repeat (30) @(posedge clk_i);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
